// ----- src/zero_run_bit_packer_top_macros.svh -----
// Assertion macros shared by the zero-run bit packer RTL.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef ZERO_RUN_BIT_PACKER_TOP_MACROS_SVH
`define ZERO_RUN_BIT_PACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZRBP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zrbp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ZRBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zrbp assertion failed");

`endif

// ----- src/zrbp_pkg.sv -----
// Package for the zero-run bit packer: command types and code constants.
// Used by the front, queue, back and top-level modules.
package zrbp_pkg;

	// Kind of work the back end performs for one item.
	typedef enum logic [1:0] {
		CMD_ENCODE = 2'd0,
		CMD_ERROR  = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_kind_t;

	// Classified item passed from the front to the back through the queue.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] code;
		logic [4:0]  nbits;
	} cmd_t;

	localparam logic [8:0]  LONG_RUN_MIN   = 9'd18;
	localparam logic [8:0]  RUN_MAX        = 9'd273;
	localparam logic [15:0] LONG_CODE_MARK = 16'h8000;
	localparam logic [4:0]  NONZERO_BITS   = 5'd9;
	localparam logic [4:0]  LONG_BITS      = 5'd16;
	localparam logic [4:0]  WINDOW_BITS    = 5'd24;

endpackage

// ----- src/zrbp_front.sv -----
// Front end of the zero-run bit packer: accepts items and classifies them.
// Depends on zrbp_pkg for the command type.
module zrbp_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        pixel,
	input  logic [8:0]        run_length,
	input  logic              q_full,
	output logic              q_push,
	output zrbp_pkg::cmd_t    q_cmd
);
	import zrbp_pkg::*;

	logic [8:0] long_off;

	// An item is taken whenever the queue has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Offset of a long zero run from its minimum.
	assign long_off = run_length - LONG_RUN_MIN;

	// Classify the item into a flush, an error or a code of a given length.
	always_comb begin
		q_cmd.kind  = CMD_ENCODE;
		q_cmd.code  = 16'h0000;
		q_cmd.nbits = 5'd0;
		priority if (req_type) begin
			q_cmd.kind = CMD_FLUSH;
		end else if (pixel != 8'h00) begin
			if (run_length > 9'd1) begin
				q_cmd.kind = CMD_ERROR;
			end else begin
				q_cmd.code  = {7'b0000000, 1'b1, pixel};
				q_cmd.nbits = NONZERO_BITS;
			end
		end else if (run_length < LONG_RUN_MIN) begin
			q_cmd.nbits = run_length[4:0];
		end else if (run_length > RUN_MAX) begin
			q_cmd.kind = CMD_ERROR;
		end else begin
			q_cmd.code  = LONG_CODE_MARK | {8'h00, long_off[8:1]};
			q_cmd.nbits = run_length[0] ? (LONG_BITS + 5'd1) : LONG_BITS;
		end
	end

endmodule

// ----- src/zrbp_queue.sv -----
// Two-entry queue of classified commands between the front and back ends.
// Depends on zrbp_pkg for the command type.
module zrbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  zrbp_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output zrbp_pkg::cmd_t head_cmd
);
	import zrbp_pkg::*;

	cmd_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head_cmd  = slots_q[rd_ptr_q];

	// Storage for the queued commands.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ----- src/zrbp_back.sv -----
// Back end of the zero-run bit packer: packs codes into bytes and emits them.
// Depends on zrbp_pkg and on the assertion macro header.
module zrbp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  zrbp_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           status,
	output logic           last
);
	import zrbp_pkg::*;
	`include "zero_run_bit_packer_top_macros.svh"

	logic [7:0]  pend_bits_q;
	logic [2:0]  pend_cnt_q;
	logic [23:0] win_q;
	logic [1:0]  left_q;
	logic        err_q;

	logic        out_free;
	logic [4:0]  total;
	logic [4:0]  shamt;
	logic [23:0] window;
	logic [1:0]  nbytes;
	logic [7:0]  next_pend;

	// The output register frees up when empty or when its final byte is taken.
	assign out_free = (left_q == 2'd0) || ((left_q == 2'd1) && out_ready);
	assign q_pop    = q_not_empty && out_free;

	assign out_valid = (left_q != 2'd0);
	assign out_byte  = win_q[23:16];
	assign status    = err_q;
	assign last      = (left_q == 2'd1);

	// Place the code right after the pending bits in a 24-bit window.
	assign total  = {2'b00, pend_cnt_q} + q_cmd.nbits;
	assign shamt  = WINDOW_BITS - total;
	assign window = {pend_bits_q, 16'h0000} | ({8'h00, q_cmd.code} << shamt);
	assign nbytes = total[4:3];

	// The partial byte left after the complete ones.
	always_comb begin
		unique case (nbytes)
			2'd0:    next_pend = window[23:16];
			2'd1:    next_pend = window[15:8];
			2'd2:    next_pend = window[7:0];
			default: next_pend = 8'h00;
		endcase
	end

	// Pending partial byte and output byte sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= 8'h00;
			pend_cnt_q  <= 3'd0;
			left_q      <= 2'd0;
			err_q       <= 1'b0;
		end else if (q_pop) begin
			unique case (q_cmd.kind)
				CMD_FLUSH: begin
					left_q      <= (pend_cnt_q != 3'd0) ? 2'd1 : 2'd0;
					err_q       <= 1'b0;
					pend_bits_q <= 8'h00;
					pend_cnt_q  <= 3'd0;
				end
				CMD_ERROR: begin
					left_q <= 2'd1;
					err_q  <= 1'b1;
				end
				CMD_ENCODE: begin
					left_q      <= nbytes;
					err_q       <= 1'b0;
					pend_bits_q <= next_pend;
					pend_cnt_q  <= total[2:0];
				end
				default: begin
					left_q <= 2'd0;
				end
			endcase
		end else if (out_valid && out_ready) begin
			left_q <= left_q - 2'd1;
		end
	end

	// Output byte window; shifts one byte per accepted output byte.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			unique case (q_cmd.kind)
				CMD_FLUSH:  win_q <= {pend_bits_q, 16'h0000};
				CMD_ENCODE: win_q <= window;
				default:    win_q <= 24'h000000;
			endcase
		end else if (out_valid && out_ready) begin
			win_q <= {win_q[15:0], 8'h00};
		end
	end

	// An error result is always a single zero byte.
	`ZRBP_ASSERT_IMPL(a_err_single, out_valid && err_q, last && (out_byte == 8'h00))
	// A command is taken only when the output register is free.
	`ZRBP_ASSERT_IMPL(a_pop_free, q_pop, (left_q == 2'd0) || ((left_q == 2'd1) && out_ready))
	// A flush always leaves nothing pending.
	`ZRBP_ASSERT_NEXT(a_flush_clears, q_pop && (q_cmd.kind == CMD_FLUSH), pend_cnt_q == 3'd0)

endmodule

// ----- src/zero_run_bit_packer_top.sv -----
// Zero-run bit packer: each item encodes a pixel run (or flushes the partial
// byte) and produces zero to three packed bytes, earliest bit in the MSB.
// A new item is accepted every cycle while the two-entry command queue has
// room; bytes leave one per cycle while out_ready is high, and an item holds
// the output until its final byte is taken. The output byte register in the
// back end sets that rate. Error results carry status 1 and a zero byte;
// last marks the final byte of each item that produces bytes.
module zero_run_bit_packer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] pixel,
	input  logic [8:0] run_length,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       status,
	output logic       last
);
	import zrbp_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;

	// Front end: take and classify items.
	zrbp_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.pixel      (pixel),
		.run_length (run_length),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	// Command queue between the two ends.
	zrbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (head_cmd)
	);

	// Back end: bit packing and byte output.
	zrbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_cmd       (head_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.status      (status),
		.last        (last)
	);

endmodule
